@@ rtl/pfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    // fixed field widths
    localparam int MODE_W   = 1;
    localparam int PIDX_W   = 4;
    localparam int AMT_W    = 16;
    localparam int REQN_W   = 8;
    localparam int PNUM_W   = 4;
    localparam int LEFT_W   = 16;
    localparam int POLICY_W = 2;
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // input item modes
    localparam logic [MODE_W-1:0] MODE_LOAD = 1'b0;
    localparam logic [MODE_W-1:0] MODE_REQ  = 1'b1;

    // fit policies; the unused code behaves as first fit
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    // search token control moving down the cell chain
    typedef struct packed {
        logic valid;
        logic found;
    } t_scan;

endpackage

`default_nettype wire

@@ rtl/pfa_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pfa_in_if;
    import pfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [PIDX_W-1:0]   partition_index;
    logic [AMT_W-1:0]    amount;

    modport source (output valid, output mode, output partition_index, output amount,
                    input ready);
    modport sink   (input valid, input mode, input partition_index, input amount,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/pfa_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pfa_out_if;
    import pfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQN_W-1:0]   request_number;
    logic                allocated;
    logic [PNUM_W-1:0]   partition_number;
    logic [LEFT_W-1:0]   space_left;

    modport source (output valid, output request_number, output allocated,
                    output partition_number, output space_left, input ready);
    modport sink   (input valid, input request_number, input allocated,
                    input partition_number, input space_left, output ready);
endinterface

`default_nettype wire

@@ rtl/pfa_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfa_cell #(
    parameter int J      = 0,
    parameter int IDX_W  = 4,
    parameter int WIX    = 4,
    parameter int SIZE_W = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [pfa_pkg::CNT_W-1:0]   i_count,
    input  wire logic [pfa_pkg::POLICY_W-1:0] i_policy,
    input  wire logic [SIZE_W-1:0]           i_amt,
    input  wire logic                        i_wr_en,
    input  wire logic [WIX-1:0]              i_wr_idx,
    input  wire logic [SIZE_W-1:0]           i_wr_data,
    input  wire pfa_pkg::t_scan              i_scan,
    input  wire logic [IDX_W-1:0]            i_idx,
    input  wire logic [SIZE_W-1:0]           i_size,
    output pfa_pkg::t_scan                   o_scan,
    output logic [IDX_W-1:0]                 o_idx,
    output logic [SIZE_W-1:0]                o_size
);
    import pfa_pkg::*;

    localparam int CW = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam logic [CW-1:0]    J_CMP = CW'(J);
    localparam logic [WIX-1:0]   J_WR  = WIX'(J);
    localparam logic [IDX_W-1:0] J_IDX = IDX_W'(J);

    logic [SIZE_W-1:0] r_free;
    t_scan             r_scan;
    logic [IDX_W-1:0]  r_idx;
    logic [SIZE_W-1:0] r_size;

    logic in_range;
    logic fits;
    logic better;
    logic take;

    assign in_range = J_CMP < CW'(i_count);
    assign fits     = r_free >= i_amt;

    always_comb begin
        case (i_policy)
            POLICY_BEST:  better = i_size > r_free;
            POLICY_WORST: better = i_size < r_free;
            default:      better = 1'b0;
        endcase
    end

    assign take = i_scan.valid && in_range && fits && (!i_scan.found || better);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_idx == J_WR) begin
            r_free <= i_wr_data;
        end
        r_idx  <= take ? J_IDX : i_idx;
        r_size <= take ? r_free : i_size;
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan.valid <= i_scan.valid;
            r_scan.found <= i_scan.valid && (i_scan.found || take);
        end
    end

    assign o_scan = r_scan;
    assign o_idx  = r_idx;
    assign o_size = r_size;

endmodule

`default_nettype wire

@@ rtl/partition_fit_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Fixed partition allocator: one cell per partition, a search token walks the chain.
// Load item: no result; the next item can follow in the next cycle.
// Request item: no next transfer until the result is registered; launch, then the token passes
//   one cell per cycle, then the write-back, which waits while the result register is held.
// Reset: policy first fit, partition count 16, request counter zero, no result pending;
//   partition sizes are not cleared and must be loaded before they are searched.
module partition_fit_allocator_core #(
    parameter int NUM_PARTITIONS = 16,
    parameter int SIZE_WIDTH     = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pfa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pfa_in_if.sink                               i_in,
    pfa_out_if.source                            o_out
);
    import pfa_pkg::*;

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int WIX   = (IDX_W > PIDX_W) ? IDX_W : PIDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                r_state;
    logic                  r_launch;
    logic [POLICY_W-1:0]   r_policy;
    logic [CNT_W-1:0]      r_count;
    logic [REQN_W-1:0]     r_req_cnt;
    logic [SIZE_WIDTH-1:0] r_amt;
    logic                  r_best_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [SIZE_WIDTH-1:0] r_best_size;
    logic                  r_out_valid;
    logic [REQN_W-1:0]     r_out_reqn;
    logic                  r_out_alloc;
    logic [PNUM_W-1:0]     r_out_pnum;
    logic [LEFT_W-1:0]     r_out_left;

    logic                  accept;
    logic                  load_ok;
    logic                  out_free;
    logic [SIZE_WIDTH-1:0] diff;
    logic                  wr_en;
    logic [WIX-1:0]        wr_idx;
    logic [SIZE_WIDTH-1:0] wr_data;

    t_scan                 c_scan [NUM_PARTITIONS+1];
    logic [IDX_W-1:0]      c_idx  [NUM_PARTITIONS+1];
    logic [SIZE_WIDTH-1:0] c_size [NUM_PARTITIONS+1];

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && (r_state == ST_IDLE);
    assign load_ok    = 32'(i_in.partition_index) < 32'(NUM_PARTITIONS);
    assign out_free   = !r_out_valid || o_out.ready;
    assign diff       = r_best_size - r_amt;

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = WIX'(r_best_idx);
        wr_data = diff;
        if (accept && i_in.mode == MODE_LOAD && load_ok) begin
            wr_en   = 1'b1;
            wr_idx  = WIX'(i_in.partition_index);
            wr_data = SIZE_WIDTH'(i_in.amount);
        end else if (r_state == ST_DONE && out_free && r_best_found) begin
            wr_en = 1'b1;
        end
    end

    // chain head: fresh token, nothing found yet
    assign c_scan[0].valid = r_launch;
    assign c_scan[0].found = 1'b0;
    assign c_idx[0]        = '0;
    assign c_size[0]       = '0;

    for (genvar g = 0; g < NUM_PARTITIONS; g++) begin : g_cell
        pfa_cell #(
            .J      (g),
            .IDX_W  (IDX_W),
            .WIX    (WIX),
            .SIZE_W (SIZE_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_count   (r_count),
            .i_policy  (r_policy),
            .i_amt     (r_amt),
            .i_wr_en   (wr_en),
            .i_wr_idx  (wr_idx),
            .i_wr_data (wr_data),
            .i_scan    (c_scan[g]),
            .i_idx     (c_idx[g]),
            .i_size    (c_size[g]),
            .o_scan    (c_scan[g+1]),
            .o_idx     (c_idx[g+1]),
            .o_size    (c_size[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_launch    <= 1'b0;
            r_policy    <= POLICY_FIRST;
            r_count     <= CNT_RESET;
            r_req_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIT_POLICY: r_policy <= i_cfg_data[POLICY_W-1:0];
                    CFG_PART_COUNT: r_count  <= i_cfg_data[CNT_W-1:0];
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_in.mode == MODE_REQ) begin
                            r_amt     <= SIZE_WIDTH'(i_in.amount);
                            r_req_cnt <= r_req_cnt + REQN_W'(1);
                            r_launch  <= 1'b1;
                            r_state   <= ST_SCAN;
                        end else if (load_ok) begin
                            r_req_cnt <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (c_scan[NUM_PARTITIONS].valid) begin
                        r_best_found <= c_scan[NUM_PARTITIONS].found;
                        r_best_idx   <= c_idx[NUM_PARTITIONS];
                        r_best_size  <= c_size[NUM_PARTITIONS];
                        r_state      <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // result register must be free before the write-back commits
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_reqn  <= r_req_cnt;
                        r_out_alloc <= r_best_found;
                        r_out_pnum  <= r_best_found ? PNUM_W'(r_best_idx) : '0;
                        r_out_left  <= r_best_found ? LEFT_W'(diff) : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.request_number   = r_out_reqn;
    assign o_out.allocated        = r_out_alloc;
    assign o_out.partition_number = r_out_pnum;
    assign o_out.space_left       = r_out_left;

endmodule

`default_nettype wire

@@ verif/partition_fit_allocator_core_tb.sv @@
`timescale 1ns / 1ps

module partition_fit_allocator_core_tb;
    import pfa_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int NUM_PART    = 16;
    localparam int SETTLE_CYC  = 2 * (NUM_PART + 3);
    localparam int HOLD_CYC    = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TIMEOUT_NS  = 5_000_000;
    localparam int NUM_PHASES  = 14;
    localparam int HOLD_PHASE  = 2;
    localparam int LONG_PHASE  = 6;
    localparam int CALM_FROM   = 12;

    // unused policy code, decoded as first fit
    localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;

    typedef struct packed {
        logic [REQN_W-1:0] request_number;
        logic              allocated;
        logic [PNUM_W-1:0] partition_number;
        logic [LEFT_W-1:0] space_left;
    } alloc_res_t;

    typedef enum logic {ROW_ITEM, ROW_SETTING} row_kind_e;

    typedef struct {
        row_kind_e           kind;
        logic [MODE_W-1:0]   mode;
        logic [PIDX_W-1:0]   idx;
        logic [AMT_W-1:0]    amt;
        bit                  pinned;
        alloc_res_t          res;
        logic [POLICY_W-1:0] policy;
        logic [CNT_W-1:0]    count;
    } plan_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pfa_in_if  req_ch ();
    pfa_out_if res_ch ();

    partition_fit_allocator_core #(
        .NUM_PARTITIONS(NUM_PART),
        .SIZE_WIDTH    (AMT_W)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (req_ch),
        .o_out     (res_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // allocator mirror
    logic [AMT_W-1:0]    part_free [NUM_PART];
    logic [REQN_W-1:0]   req_seq    = '0;
    logic [POLICY_W-1:0] cfg_policy = POLICY_FIRST;
    logic [CNT_W-1:0]    cfg_count  = CNT_RESET;

    alloc_res_t alloc_due_q[$];
    plan_row_t  plan_q[$];

    // typed-in expectation travels with the item on the channel
    bit         item_pinned;
    alloc_res_t item_pinned_res;

    bit hold_results = 1'b0;
    bit idle_on      = 1'b1;

    int n_loads    = 0;
    int n_reqs     = 0;
    int n_results  = 0;
    int n_alloc    = 0;
    int n_settings = 0;
    int n_fail     = 0;

    int unsigned dir_sizes[NUM_PART] = '{100, 65535, 0, 50, 200, 30, 500, 80,
                                         1000, 60, 40, 300, 20, 700, 10, 32768};
    int unsigned count_sweep[5] = '{16, 1, 31, 0, 17};

    function automatic bit predict_alloc(input logic [MODE_W-1:0] mode,
                                         input logic [PIDX_W-1:0] idx,
                                         input logic [AMT_W-1:0] amt,
                                         output alloc_res_t res);
        int span;
        int pick;
        bit hit;
        res = '0;
        if (mode == MODE_LOAD) begin
            part_free[idx] = amt;
            req_seq = '0;
            return 1'b0;
        end
        req_seq = req_seq + REQN_W'(1);
        span = (int'(cfg_count) > NUM_PART) ? NUM_PART : int'(cfg_count);
        hit = 1'b0;
        pick = 0;
        for (int j = 0; j < span; j++) begin
            if (part_free[j] >= amt) begin
                if (!hit) begin
                    hit = 1'b1;
                    pick = j;
                    if (cfg_policy != POLICY_BEST && cfg_policy != POLICY_WORST) break;
                end else if (cfg_policy == POLICY_BEST && part_free[j] < part_free[pick]) begin
                    pick = j;
                end else if (cfg_policy == POLICY_WORST && part_free[j] > part_free[pick]) begin
                    pick = j;
                end
            end
        end
        res.request_number = req_seq;
        if (hit) begin
            part_free[pick] = part_free[pick] - amt;
            res.allocated = 1'b1;
            res.partition_number = PNUM_W'(pick);
            res.space_left = part_free[pick];
        end
        return 1'b1;
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount(input bit for_load);
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll < 5) return AMT_W'($urandom_range(0, 65535));
        return for_load ? AMT_W'($urandom_range(100, 3000)) : AMT_W'($urandom_range(1, 400));
    endfunction

    function automatic void plan_load(input int idx, input int unsigned amt);
        plan_q.push_back('{ROW_ITEM, MODE_LOAD, PIDX_W'(idx), AMT_W'(amt), 1'b0, '0,
                           POLICY_FIRST, CNT_RESET});
    endfunction

    function automatic void plan_req(input int unsigned amt, input int unsigned reqn,
                                     input bit alloc, input int unsigned pnum,
                                     input int unsigned left);
        alloc_res_t r;
        r = '{REQN_W'(reqn), alloc, PNUM_W'(pnum), LEFT_W'(left)};
        plan_q.push_back('{ROW_ITEM, MODE_REQ, '1, AMT_W'(amt), 1'b1, r,
                           POLICY_FIRST, CNT_RESET});
    endfunction

    function automatic void plan_setting(input logic [POLICY_W-1:0] policy,
                                         input int unsigned count);
        plan_q.push_back('{ROW_SETTING, MODE_LOAD, '0, '0, 1'b0, '0, policy, CNT_W'(count)});
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    task automatic offer_item(input logic [MODE_W-1:0] mode, input logic [PIDX_W-1:0] idx,
                              input logic [AMT_W-1:0] amt, input bit pinned,
                              input alloc_res_t pres);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.mode            <= mode;
        req_ch.partition_index <= idx;
        req_ch.amount          <= amt;
        item_pinned            <= pinned;
        item_pinned_res        <= pres;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // loads give no result, so allow a full search time after the last one
    task automatic wait_allocator_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (alloc_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic program_allocator(input logic [POLICY_W-1:0] policy,
                                     input logic [CNT_W-1:0] count, input bit noisy);
        logic [CFG_DATA_W-POLICY_W-1:0] pad;
        pad = noisy ? (CFG_DATA_W - POLICY_W)'($urandom_range(0, 7)) : '0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FIT_POLICY;
        i_cfg_data <= {pad, policy};
        @(posedge i_clk);
        cfg_policy = policy;
        i_cfg_idx  <= CFG_PART_COUNT;
        i_cfg_data <= CFG_DATA_W'(count);
        @(posedge i_clk);
        cfg_count = count;
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // input side: every transfer goes through the mirror
    always @(posedge i_clk) begin : item_watch
        alloc_res_t r;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            if (req_ch.mode == MODE_LOAD) n_loads++;
            else n_reqs++;
            if (predict_alloc(req_ch.mode, req_ch.partition_index, req_ch.amount, r))
                alloc_due_q.push_back(item_pinned ? item_pinned_res : r);
        end
    end

    always @(posedge i_clk) begin : result_check
        alloc_res_t want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (res_ch.allocated) n_alloc++;
            if (alloc_due_q.size() == 0) begin
                $error("result transfer with no request outstanding");
                n_fail++;
            end else begin
                want = alloc_due_q.pop_front();
                check_field("request_number", want.request_number, res_ch.request_number);
                check_field("allocated", want.allocated, res_ch.allocated);
                check_field("partition_number", want.partition_number,
                            res_ch.partition_number);
                check_field("space_left", want.space_left, res_ch.space_left);
            end
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            if (hold_results) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
                hold_results = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d results outstanding", alloc_due_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int n_items;
        int unsigned cnt;
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= CFG_FIT_POLICY;
        i_cfg_data             <= '0;
        req_ch.valid           <= 1'b0;
        req_ch.mode            <= MODE_LOAD;
        req_ch.partition_index <= '0;
        req_ch.amount          <= '0;
        item_pinned            <= 1'b0;
        item_pinned_res        <= '0;
        foreach (part_free[i]) part_free[i] = '0;

        // every partition is loaded before the first search
        for (int i = 0; i < NUM_PART; i++) plan_load(i, dir_sizes[i]);
        plan_req(0, 1, 1'b1, 0, 100);
        plan_req(65535, 2, 1'b1, 1, 0);
        plan_req(65535, 3, 1'b0, 0, 0);
        plan_req(32768, 4, 1'b1, 15, 0);
        plan_req(150, 5, 1'b1, 4, 50);
        plan_load(2, 5);
        plan_req(5, 1, 1'b1, 0, 95);
        plan_setting(POLICY_FIRST, 0);
        plan_req(1, 2, 1'b0, 0, 0);
        plan_setting(POLICY_SPARE, 31);
        plan_req(1, 3, 1'b1, 0, 94);
        plan_setting(POLICY_BEST, 31);
        plan_req(10, 4, 1'b1, 14, 0);
        plan_req(50, 5, 1'b1, 3, 0);    // tie between 3 and 4
        plan_setting(POLICY_WORST, 31);
        plan_req(1, 6, 1'b1, 8, 999);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan_q[r]) begin
            if (plan_q[r].kind == ROW_SETTING) begin
                wait_allocator_idle();
                program_allocator(plan_q[r].policy, plan_q[r].count, 1'b0);
            end else begin
                offer_item(plan_q[r].mode, plan_q[r].idx, plan_q[r].amt,
                           plan_q[r].pinned, plan_q[r].res);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_allocator_idle();
            if (ph >= CALM_FROM) idle_on = 1'b0;
            cnt = (ph < 5) ? count_sweep[ph] : $urandom_range(0, 31);
            program_allocator(POLICY_W'(ph % 4), CNT_W'(cnt), 1'b1);
            if (ph == HOLD_PHASE) hold_results = 1'b1;
            // no loads in the long phase so the request number wraps
            n_items = (ph == LONG_PHASE) ? 270 : 35;
            for (int k = 0; k < n_items; k++) begin
                if (ph != LONG_PHASE && $urandom_range(0, 3) == 0)
                    offer_item(MODE_LOAD, PIDX_W'($urandom_range(0, NUM_PART - 1)),
                               pick_amount(1'b1), 1'b0, '0);
                else
                    offer_item(MODE_REQ, PIDX_W'($urandom_range(0, NUM_PART - 1)),
                               pick_amount(1'b0), 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && alloc_due_q.size() != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (alloc_due_q.size() != 0) begin
            $error("%0d requests never produced a result", alloc_due_q.size());
            n_fail++;
        end

        $display("Covered %0d loads and %0d requests under %0d policy/count settings,",
                 n_loads, n_reqs, n_settings);
        $display("with %0d results compared (%0d allocated, %0d refused).",
                 n_results, n_alloc, n_results - n_alloc);
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
